// ===== design/tofm_pkg.sv =====
// Shared types, defaults and sine table builder for the two-operator FM oscillator.
package tofm_pkg;

    localparam int TABLE_BITS_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    // 2*pi in unsigned Q30.
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Denominators (2k)(2k+1) of the sine series terms.
    localparam logic [63:0] SERIES_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Operand pairs of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_BASE_HARM = 3'd0,
        MUL_HARM_IDX  = 3'd1,
        MUL_BASE_HI   = 3'd2,
        MUL_INTERP    = 3'd3,
        MUL_DEV_LO    = 3'd4,
        MUL_DEV_HI    = 3'd5
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     adv_m;
        logic     adv_c;
        logic     rd_y;
        logic     rd_y1;
        logic     w_cap;
        logic     samp_cap;
        logic     acc_cap;
        logic     dev_cap;
        logic     step_cap;
        logic     out_cap;
    } t_cmd;

    // Quarter-wave sine by integer series, unsigned Q1.(sample_bits-1).
    function automatic logic [31:0] quarter_sine(input int unsigned m,
                                                 input int unsigned table_bits,
                                                 input int unsigned sample_bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        half;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = (TWO_PI_Q30 * 64'(m)) >> table_bits;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / SERIES_DIV[k];
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        half = 64'd1 << (sample_bits - 1);
        v    = ($unsigned(sum) * half + (64'd1 << 29)) >> 30;
        if (v > half - 64'd1) begin
            v = half - 64'd1;
        end
        return v[31:0];
    endfunction

    // Full-wave table entry n (0..2^table_bits, the last one a guard copy of entry 0).
    function automatic logic signed [31:0] sine_entry(input int unsigned n,
                                                      input int unsigned table_bits,
                                                      input int unsigned sample_bits);
        int unsigned        rom_len;
        int unsigned        k;
        int unsigned        half;
        int unsigned        r;
        int unsigned        m;
        logic signed [31:0] v;
        rom_len = 1 << table_bits;
        k       = n & (rom_len - 1);
        half    = rom_len >> 1;
        r       = (k < half) ? k : k - half;
        m       = (r <= (rom_len >> 2)) ? r : half - r;
        v       = $signed(quarter_sine(m, table_bits, sample_bits));
        return (k < half) ? v : -v;
    endfunction

endpackage

// ===== design/tofm_ctrl.sv =====
// Sequencer for the FM oscillator: steps one item through the shared datapath.
module tofm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tofm_pkg::t_cmd  o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_MUL_MS = 16'b0000_0000_0000_0010,
        S_ADV_M  = 16'b0000_0000_0000_0100,
        S_M_Y    = 16'b0000_0000_0000_1000,
        S_M_Y1   = 16'b0000_0000_0001_0000,
        S_M_MUL  = 16'b0000_0000_0010_0000,
        S_M_SUM  = 16'b0000_0000_0100_0000,
        S_MUL_DL = 16'b0000_0000_1000_0000,
        S_MUL_DH = 16'b0000_0001_0000_0000,
        S_DEV    = 16'b0000_0010_0000_0000,
        S_STEP   = 16'b0000_0100_0000_0000,
        S_ADV_C  = 16'b0000_1000_0000_0000,
        S_C_Y    = 16'b0001_0000_0000_0000,
        S_C_Y1   = 16'b0010_0000_0000_0000,
        S_C_MUL  = 16'b0100_0000_0000_0000,
        S_OUT    = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = tofm_pkg::MUL_BASE_HARM;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_MS;
                end
            end
            S_MUL_MS: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tofm_pkg::MUL_BASE_HARM;
                n_state       = S_ADV_M;
            end
            S_ADV_M: begin
                o_cmd.adv_m   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tofm_pkg::MUL_HARM_IDX;
                n_state       = S_M_Y;
            end
            S_M_Y: begin
                o_cmd.rd_y    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tofm_pkg::MUL_BASE_HI;
                n_state       = S_M_Y1;
            end
            S_M_Y1: begin
                o_cmd.rd_y1 = 1'b1;
                o_cmd.w_cap = 1'b1;
                n_state     = S_M_MUL;
            end
            S_M_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tofm_pkg::MUL_INTERP;
                n_state       = S_M_SUM;
            end
            S_M_SUM: begin
                o_cmd.samp_cap = 1'b1;
                n_state        = S_MUL_DL;
            end
            S_MUL_DL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tofm_pkg::MUL_DEV_LO;
                n_state       = S_MUL_DH;
            end
            S_MUL_DH: begin
                o_cmd.acc_cap = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tofm_pkg::MUL_DEV_HI;
                n_state       = S_DEV;
            end
            S_DEV: begin
                o_cmd.dev_cap = 1'b1;
                n_state       = S_STEP;
            end
            S_STEP: begin
                o_cmd.step_cap = 1'b1;
                n_state        = S_ADV_C;
            end
            S_ADV_C: begin
                o_cmd.adv_c = 1'b1;
                n_state     = S_C_Y;
            end
            S_C_Y: begin
                o_cmd.rd_y = 1'b1;
                n_state    = S_C_Y1;
            end
            S_C_Y1: begin
                o_cmd.rd_y1 = 1'b1;
                n_state     = S_C_MUL;
            end
            S_C_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tofm_pkg::MUL_INTERP;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // The product is held until the output register is free.
                if (out_free) begin
                    o_cmd.out_cap = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_cap) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/tofm_datapath.sv =====
// Datapath of the FM oscillator: phase accumulators, sine table, shared multiplier.
module tofm_datapath #(
    parameter int TABLE_BITS  = tofm_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = tofm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tofm_pkg::t_cmd      i_cmd,
    input  logic [30:0]         i_base_step,
    input  logic [15:0]         i_harmonicity,
    input  logic [15:0]         i_mod_index,
    output logic signed [15:0]  o_sample_out
);

    localparam int ROM_LEN   = 1 << TABLE_BITS;
    localparam int FRAC_BITS = 32 - TABLE_BITS;

    logic signed [SAMPLE_BITS-1:0] sine_lut [ROM_LEN+1];

    genvar g;
    for (g = 0; g <= ROM_LEN; g++) begin : g_lut
        assign sine_lut[g] = SAMPLE_BITS'(tofm_pkg::sine_entry(g, TABLE_BITS, SAMPLE_BITS));
    end

    logic [30:0]                   r_base;
    logic [15:0]                   r_harm;
    logic [15:0]                   r_idx;
    logic [31:0]                   r_mphase;
    logic [31:0]                   r_cphase;
    logic [31:0]                   r_ph;
    logic [63:0]                   r_prod;
    logic [63:0]                   r_acc;
    logic [38:0]                   r_w;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [SAMPLE_BITS-1:0] r_y1;
    logic signed [SAMPLE_BITS-1:0] r_samp;
    logic signed [39:0]            r_dev;
    logic [31:0]                   r_cstep;
    logic signed [15:0]            r_out;

    logic [TABLE_BITS-1:0]         idx;
    logic [TABLE_BITS:0]           rd_addr;
    logic signed [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS-1:0]        mag;
    logic signed [32:0]            op_a;
    logic signed [32:0]            op_b;
    logic signed [65:0]            mul_full;
    logic signed [63:0]            interp_shift;
    logic signed [SAMPLE_BITS-1:0] interp_sum;
    logic [63:0]                   dev_sum;
    logic [38:0]                   dev_mag;
    logic signed [41:0]            cstep_wide;
    logic [31:0]                   cstep_sat;
    logic signed [15:0]            out_conv;

    assign idx     = r_ph[31:FRAC_BITS];
    assign rd_addr = i_cmd.rd_y1 ? ({1'b0, idx} + 1'b1) : {1'b0, idx};
    assign diff    = {r_y1[SAMPLE_BITS-1], r_y1} - {r_y[SAMPLE_BITS-1], r_y};
    assign mag     = r_samp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_samp) : r_samp;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.mul_sel)
            tofm_pkg::MUL_BASE_HARM: begin
                op_a = $signed({2'b0, r_base});
                op_b = $signed({17'b0, r_harm});
            end
            tofm_pkg::MUL_HARM_IDX: begin
                op_a = $signed({17'b0, r_harm});
                op_b = $signed({17'b0, r_idx});
            end
            tofm_pkg::MUL_BASE_HI: begin
                op_a = $signed({2'b0, r_base});
                op_b = $signed({1'b0, r_prod[31:0]});
            end
            tofm_pkg::MUL_INTERP: begin
                op_a = 33'(diff);
                op_b = $signed(33'(r_ph[FRAC_BITS-1:0]));
            end
            tofm_pkg::MUL_DEV_LO: begin
                op_a = $signed({1'b0, r_w[31:0]});
                op_b = $signed(33'(mag));
            end
            tofm_pkg::MUL_DEV_HI: begin
                op_a = $signed(33'(r_w[38:32]));
                op_b = $signed(33'(mag));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_full     = op_a * op_b;
    assign interp_shift = $signed(r_prod) >>> FRAC_BITS;
    assign interp_sum   = r_y + $signed(interp_shift[SAMPLE_BITS-1:0]);

    // Low partial product plus the high one moved up by 32 bits.
    assign dev_sum = r_acc + {r_prod[31:0], 32'b0};
    assign dev_mag = dev_sum[SAMPLE_BITS+37:SAMPLE_BITS-1];

    assign cstep_wide = $signed({11'b0, r_base}) + $signed({r_dev[39], r_dev, 1'b0});

    always_comb begin
        if (cstep_wide[41:31] == '0 || cstep_wide[41:31] == '1) begin
            cstep_sat = cstep_wide[31:0];
        end else if (cstep_wide[41]) begin
            cstep_sat = 32'h8000_0000;
        end else begin
            cstep_sat = 32'h7FFF_FFFF;
        end
    end

    if (SAMPLE_BITS >= 16) begin : g_conv_down
        assign out_conv = interp_sum[SAMPLE_BITS-1:SAMPLE_BITS-16];
    end else begin : g_conv_up
        assign out_conv = 16'(interp_sum) <<< (16 - SAMPLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mphase <= '0;
            r_cphase <= '0;
        end else begin
            if (i_cmd.adv_m) begin
                r_mphase <= r_mphase + r_prod[43:12];
            end
            if (i_cmd.adv_c) begin
                r_cphase <= r_cphase + r_cstep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base_step;
            r_harm <= i_harmonicity;
            r_idx  <= i_mod_index;
        end
        if (i_cmd.adv_m) begin
            r_ph <= r_mphase;
        end else if (i_cmd.adv_c) begin
            r_ph <= r_cphase;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_full[63:0];
        end
        if (i_cmd.rd_y) begin
            r_y <= sine_lut[rd_addr];
        end
        if (i_cmd.rd_y1) begin
            r_y1 <= sine_lut[rd_addr];
        end
        if (i_cmd.w_cap) begin
            r_w <= r_prod[62:24];
        end
        if (i_cmd.samp_cap) begin
            r_samp <= interp_sum;
        end
        if (i_cmd.acc_cap) begin
            r_acc <= r_prod;
        end
        if (i_cmd.dev_cap) begin
            r_dev <= r_samp[SAMPLE_BITS-1] ? -$signed({1'b0, dev_mag})
                                           : $signed({1'b0, dev_mag});
        end
        if (i_cmd.step_cap) begin
            r_cstep <= cstep_sat;
        end
        if (i_cmd.out_cap) begin
            r_out <= out_conv;
        end
    end

    assign o_sample_out = r_out;

endmodule

// ===== design/two_operator_fm_oscillator.sv =====
// Top level of the two-operator FM oscillator: sequencer and datapath.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   i_base_step, i_harmonicity, i_mod_index
//   out      output     o_out_valid / i_out_stall o_sample_out
//
// The single shared 33x33 multiplier serves all seven products in turn, so a new item
// is taken only once the sequencer is back in idle with the last one finished.
// A finished sample waits in the output register while the next item is taken;
// if it is still stalled when the next sample is ready, the sequencer holds.
// Reset is synchronous and clears both phase accumulators; no clearing pass.
module two_operator_fm_oscillator #(
    parameter int TABLE_BITS  = tofm_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = tofm_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [30:0]        i_base_step,
    input  logic [15:0]        i_harmonicity,
    input  logic [15:0]        i_mod_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample_out
);

    tofm_pkg::t_cmd cmd;

    tofm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    tofm_datapath #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_base_step   (i_base_step),
        .i_harmonicity (i_harmonicity),
        .i_mod_index   (i_mod_index),
        .o_sample_out  (o_sample_out)
    );

endmodule
